// ===== rtl/core/afsk_pkg.sv =====
// Shared types, constants and the sine lookup for the AFSK bit-stuffing NRZI modulator.
// No dependencies; imported by afsk_ctrl, afsk_dp and the top level.
`default_nettype none

package afsk_pkg;

  // Phase accumulator: 7 integer bits (ROM index) and 16 fraction bits
  localparam int SINE_INDEX_W        = 7;
  localparam int PHASE_FRACTION_BITS = 16;
  localparam int STEP_W              = SINE_INDEX_W + PHASE_FRACTION_BITS;

  // Symbol length register and sample counter
  localparam int SPS_W                  = 6;
  localparam int MAX_SAMPLES_PER_SYMBOL = 32;
  localparam int CNT_W                  = $clog2(MAX_SAMPLES_PER_SYMBOL);

  localparam int SAMPLE_W = 8;
  localparam int RUN_W    = 3;

  // Stuff a symbol after this many ones in a row
  localparam logic [RUN_W-1:0] STUFF_RUN = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_MARK_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPS        = 2'd2;

  // Reset values of the configuration registers
  localparam logic [STEP_W-1:0] MARK_STEP_RST  = 23'd762601;
  localparam logic [STEP_W-1:0] SPACE_STEP_RST = 23'd1398101;
  localparam logic [SPS_W-1:0]  SPS_RST        = 6'd11;

  // First quarter wave, round(64 * sin(2*pi*i/128)), i = 0..32
  localparam logic [6:0] SINE_QUARTER [0:32] = '{
    7'd0,  7'd3,  7'd6,  7'd9,  7'd12, 7'd16, 7'd19, 7'd22,
    7'd24, 7'd27, 7'd30, 7'd33, 7'd36, 7'd38, 7'd41, 7'd43,
    7'd45, 7'd47, 7'd49, 7'd51, 7'd53, 7'd55, 7'd56, 7'd58,
    7'd59, 7'd60, 7'd61, 7'd62, 7'd63, 7'd63, 7'd64, 7'd64,
    7'd64
  };

  // Controller to datapath commands
  typedef struct packed {
    logic accept;      // item taken this cycle
    logic start_stuff; // flip tone and clear run count for a stuffing symbol
    logic code_bit;    // apply NRZI coding of the item's bit
    logic emit;        // produce one sample into the output register
    logic stuffed;     // sample belongs to a stuffing symbol
    logic last;        // final sample of this item
  } afsk_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic             stuff_req; // five ones have gone by
    logic             out_free;  // output register can take a sample
    logic [SPS_W-1:0] sym_len;   // clamped symbol length, 1..32
  } afsk_sts_t;

  // Full-wave sine from the quarter table using symmetry
  function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
    input logic [SINE_INDEX_W-1:0] idx
  );
    logic       neg;
    logic [6:0] k;
    logic [5:0] q;
    logic [7:0] mag;
    neg = (idx > 7'd64);
    k   = neg ? 7'(8'd128 - {1'b0, idx}) : idx;
    q   = (k > 7'd32) ? 6'(7'd64 - k) : k[5:0];
    mag = {1'b0, SINE_QUARTER[q]};
    return neg ? $signed(8'(-mag)) : $signed(mag);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/afsk_ctrl.sv =====
// Controller of the AFSK modulator: sequences stuffing and data symbols, counts samples.
// Depends on afsk_pkg; drives afsk_dp through afsk_cmd_t.
`default_nettype none

module afsk_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire afsk_pkg::afsk_sts_t  sts,
  output afsk_pkg::afsk_cmd_t       cmd
);
  import afsk_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SYMBOL = 1'b1;

  logic             state_r, state_nxt;
  logic             stuff_r, stuff_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             accept;
  logic             emit;
  logic             sym_last;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state_r == ST_SYMBOL) && sts.out_free;
  assign sym_last = ({1'b0, cnt_r} == 6'(sts.sym_len - 6'd1));

  // Commands to the datapath
  always_comb begin
    cmd.accept      = accept;
    cmd.start_stuff = accept && sts.stuff_req;
    cmd.code_bit    = (accept && !sts.stuff_req) || (emit && sym_last && stuff_r);
    cmd.emit        = emit;
    cmd.stuffed     = stuff_r;
    cmd.last        = sym_last && !stuff_r;
  end

  // Advance state, sample count and stuffing flag
  always_comb begin
    state_nxt = state_r;
    stuff_nxt = stuff_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SYMBOL;
          stuff_nxt = sts.stuff_req;
          cnt_nxt   = '0;
        end
      end
      ST_SYMBOL: begin
        if (emit) begin
          if (sym_last) begin
            cnt_nxt = '0;
            if (stuff_r) begin
              stuff_nxt = 1'b0;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      stuff_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      stuff_r <= stuff_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/afsk_dp.sv =====
// Datapath of the AFSK modulator: config registers, tone/run/phase state, sine lookup,
// output register. Depends on afsk_pkg; commanded by afsk_ctrl.
`default_nettype none

module afsk_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [afsk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [afsk_pkg::STEP_W-1:0]          cfg_data,
  input  wire logic                                 in_data_bit,
  input  wire afsk_pkg::afsk_cmd_t                  cmd,
  output afsk_pkg::afsk_sts_t                       sts,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic signed [afsk_pkg::SAMPLE_W-1:0]      out_sample,
  output logic                                      out_tone,
  output logic                                      out_stuffed,
  output logic                                      out_last
);
  import afsk_pkg::*;

  logic [STEP_W-1:0]          mark_step_r;
  logic [STEP_W-1:0]          space_step_r;
  logic [SPS_W-1:0]           sps_r;
  logic                       tone_r, tone_nxt;
  logic [RUN_W-1:0]           run_r, run_nxt;
  logic [STEP_W-1:0]          phase_r, phase_nxt;
  logic                       bit_r;
  logic                       bit_cur;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       out_tone_r;
  logic                       out_stuffed_r;
  logic                       out_last_r;

  assign cfg_ready = 1'b1;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_step_r  <= MARK_STEP_RST;
      space_step_r <= SPACE_STEP_RST;
      sps_r        <= SPS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MARK_STEP:  mark_step_r  <= cfg_data;
        REG_SPACE_STEP: space_step_r <= cfg_data;
        REG_SPS:        sps_r        <= cfg_data[SPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Status: clamp symbol length to 1..32
  always_comb begin
    sts.stuff_req = (run_r >= STUFF_RUN);
    sts.out_free  = !out_valid_r || out_ready;
    if (sps_r == '0) begin
      sts.sym_len = 6'd1;
    end else if (sps_r > 6'(MAX_SAMPLES_PER_SYMBOL)) begin
      sts.sym_len = 6'(MAX_SAMPLES_PER_SYMBOL);
    end else begin
      sts.sym_len = sps_r;
    end
  end

  // Hold the item's bit for coding after a stuffing symbol
  assign bit_cur = cmd.accept ? in_data_bit : bit_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      bit_r <= in_data_bit;
    end
  end

  // Tone and run count: stuffing flips, NRZI zero flips, one counts
  always_comb begin
    tone_nxt = tone_r;
    run_nxt  = run_r;
    if (cmd.start_stuff) begin
      tone_nxt = ~tone_r;
      run_nxt  = '0;
    end else if (cmd.code_bit) begin
      if (bit_cur) begin
        run_nxt = run_r + RUN_W'(1);
      end else begin
        tone_nxt = ~tone_r;
        run_nxt  = '0;
      end
    end
  end

  // Advance phase by the current tone's step; wraps at 2^23
  assign phase_nxt = cmd.emit ? (phase_r + (tone_r ? mark_step_r : space_step_r)) : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r  <= 1'b0;
      run_r   <= '0;
      phase_r <= '0;
    end else begin
      tone_r  <= tone_nxt;
      run_r   <= run_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_r      <= sine_lookup(phase_r[STEP_W-1:PHASE_FRACTION_BITS]);
      out_tone_r    <= tone_r;
      out_stuffed_r <= cmd.stuffed;
      out_last_r    <= cmd.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = sample_r;
  assign out_tone    = out_tone_r;
  assign out_stuffed = out_stuffed_r;
  assign out_last    = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/afsk_bit_stuff_nrzi_modulator_unit.sv =====
// AFSK modulator with HDLC bit stuffing and NRZI coding (mark 1200 Hz, space 2200 Hz).
//
// Input channel (in_valid/in_ready, in_data_bit): one payload bit per item, LSB first.
// Output channel (out_valid/out_ready): one sine sample per item with its tone, a flag
// for stuffing symbols and a last flag on the final sample caused by an input bit.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): 0 mark step, 1 space step
// (7.16 phase steps), 2 samples per symbol; other indexes are ignored. Always ready.
//
// Each bit gives one symbol, or two when five ones have gone by and a stuffing symbol
// goes first. A symbol is samples_per_symbol samples (clamped to 1..32). The sample
// path emits at most one sample per cycle while the output register can take one.
// The default is 11 samples per symbol. A bit is accepted in the idle state, before
// its samples are emitted; each sample is held in the output register until taken.
// The next bit is accepted while the last sample still waits in the output register.
// When the receiver stalls, the output register holds and sample production pauses.
// Reset (rst_n, synchronous) clears tone to space, run count and phase to zero and
// restores the register defaults.
`default_nettype none

module afsk_bit_stuff_nrzi_modulator_unit (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [afsk_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afsk_pkg::STEP_W-1:0]      cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_data_bit,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [afsk_pkg::SAMPLE_W-1:0]  out_sample,
  output logic                                  out_tone,
  output logic                                  out_stuffed,
  output logic                                  out_last
);
  import afsk_pkg::*;

  afsk_cmd_t cmd;
  afsk_sts_t sts;

  // Sequence symbols and samples
  afsk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold state, compute samples
  afsk_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_data_bit (in_data_bit),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_sample  (out_sample),
    .out_tone    (out_tone),
    .out_stuffed (out_stuffed),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire
